>>> rtl/core/segi_pkg.sv
// ----------------------------------------------------------------------------
// segi_pkg
// Widths, beat types and the divider stage payload for segment_intersection.
// ----------------------------------------------------------------------------
package segi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MULT_W     = 2 * DIFF_W;
    localparam int CROSS_W    = 2 * COORD_BITS + 3;
    localparam int MAG_W      = 2 * COORD_BITS + 2;
    localparam int QUO_W      = COORD_BITS + 1;
    localparam int PROD_W     = MAG_W + QUO_W;
    localparam int SUM_W      = COORD_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [MULT_W-1:0]     mult_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } in_t;

    typedef struct packed {
        logic   hit;
        coord_t point_x;
        coord_t point_y;
    } out_t;

    typedef struct packed {
        logic              hit;
        logic              neg_x;
        logic              neg_y;
        coord_t            start_x;
        coord_t            start_y;
        logic [MAG_W-1:0]  den;
        logic [PROD_W-1:0] rem_x;
        logic [PROD_W-1:0] rem_y;
        logic [QUO_W-1:0]  q_x;
        logic [QUO_W-1:0]  q_y;
    } div_t;

endpackage

>>> rtl/core/segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_intersection
// 2D segment crossing test by cross products, with the crossing point.
// ----------------------------------------------------------------------------
// Path: diffs, products, cross products, hit test, dividends, divider, result.
// Throughput: one beat per cycle; one divider step per quotient bit sets depth.
// The whole pipeline advances when the result register is free or taken.
// Reset: synchronous active-low aresetn clears all valid bits; no data reset.
module segment_intersection (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  segi_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output segi_pkg::out_t m_data
);
    import segi_pkg::*;

    localparam int DS = QUO_W;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (COORD_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    function automatic diff_t sext(input coord_t c);
        return {c[COORD_BITS-1], c};
    endfunction

    function automatic coord_t sat(input logic signed [SUM_W-1:0] v);
        coord_t r;
        if (v > SAT_HI) begin
            r = SAT_HI[COORD_BITS-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[COORD_BITS-1:0];
        end else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 1: differences
    logic   v1_reg;
    diff_t  rx1_reg, ry1_reg, sx1_reg, sy1_reg, dx1_reg, dy1_reg;
    coord_t ax1_reg, ay1_reg;

    // stage 2: products
    logic   v2_reg;
    mult_t  p_rsy_reg, p_rys_reg, p_dsy_reg, p_dys_reg, p_dry_reg, p_dyr_reg;
    diff_t  rx2_reg, ry2_reg;
    coord_t ax2_reg, ay2_reg;

    // stage 3: cross products
    logic   v3_reg;
    cross_t rxs3_reg, tn3_reg, un3_reg;
    diff_t  rx3_reg, ry3_reg;
    coord_t ax3_reg, ay3_reg;

    // stage 4: sign normalize and hit test
    cross_t rxs_n, tn_n, un_n;
    logic   hit_next;
    logic   v4_reg;
    logic   hit4_reg, negx4_reg, negy4_reg;
    logic [MAG_W-1:0] den4_reg, tn4_reg;
    logic [QUO_W-1:0] absrx4_reg, absry4_reg;
    coord_t ax4_reg, ay4_reg;

    // stage 5: dividends
    logic v5_reg;
    div_t d5_reg;

    logic dv_valid [DS+1];
    div_t dv_data  [DS+1];

    logic out_valid_reg;
    out_t out_reg;
    logic signed [SUM_W-1:0] sum_x, sum_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= s_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            out_valid_reg <= dv_valid[DS];
        end
    end

    always_comb begin
        rxs_n = rxs3_reg[CROSS_W-1] ? -rxs3_reg : rxs3_reg;
        tn_n  = rxs3_reg[CROSS_W-1] ? -tn3_reg  : tn3_reg;
        un_n  = rxs3_reg[CROSS_W-1] ? -un3_reg  : un3_reg;
        hit_next = (rxs3_reg != '0) && !tn_n[CROSS_W-1] && !un_n[CROSS_W-1]
                   && (tn_n <= rxs_n) && (un_n <= rxs_n);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rx1_reg <= sext(s_data.a_end_x) - sext(s_data.a_start_x);
            ry1_reg <= sext(s_data.a_end_y) - sext(s_data.a_start_y);
            sx1_reg <= sext(s_data.b_end_x) - sext(s_data.b_start_x);
            sy1_reg <= sext(s_data.b_end_y) - sext(s_data.b_start_y);
            dx1_reg <= sext(s_data.b_start_x) - sext(s_data.a_start_x);
            dy1_reg <= sext(s_data.b_start_y) - sext(s_data.a_start_y);
            ax1_reg <= s_data.a_start_x;
            ay1_reg <= s_data.a_start_y;

            p_rsy_reg <= mult_t'(rx1_reg) * mult_t'(sy1_reg);
            p_rys_reg <= mult_t'(ry1_reg) * mult_t'(sx1_reg);
            p_dsy_reg <= mult_t'(dx1_reg) * mult_t'(sy1_reg);
            p_dys_reg <= mult_t'(dy1_reg) * mult_t'(sx1_reg);
            p_dry_reg <= mult_t'(dx1_reg) * mult_t'(ry1_reg);
            p_dyr_reg <= mult_t'(dy1_reg) * mult_t'(rx1_reg);
            rx2_reg   <= rx1_reg;
            ry2_reg   <= ry1_reg;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;

            rxs3_reg <= cross_t'(p_rsy_reg) - cross_t'(p_rys_reg);
            tn3_reg  <= cross_t'(p_dsy_reg) - cross_t'(p_dys_reg);
            un3_reg  <= cross_t'(p_dry_reg) - cross_t'(p_dyr_reg);
            rx3_reg  <= rx2_reg;
            ry3_reg  <= ry2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;

            hit4_reg   <= hit_next;
            den4_reg   <= rxs_n[MAG_W-1:0];
            tn4_reg    <= hit_next ? tn_n[MAG_W-1:0] : '0;
            negx4_reg  <= rx3_reg[DIFF_W-1];
            negy4_reg  <= ry3_reg[DIFF_W-1];
            absrx4_reg <= rx3_reg[DIFF_W-1] ? QUO_W'(-rx3_reg) : QUO_W'(rx3_reg);
            absry4_reg <= ry3_reg[DIFF_W-1] ? QUO_W'(-ry3_reg) : QUO_W'(ry3_reg);
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;

            d5_reg.hit     <= hit4_reg;
            d5_reg.neg_x   <= negx4_reg;
            d5_reg.neg_y   <= negy4_reg;
            d5_reg.start_x <= ax4_reg;
            d5_reg.start_y <= ay4_reg;
            d5_reg.den     <= den4_reg;
            d5_reg.rem_x   <= PROD_W'(tn4_reg) * PROD_W'(absrx4_reg);
            d5_reg.rem_y   <= PROD_W'(tn4_reg) * PROD_W'(absry4_reg);
            d5_reg.q_x     <= '0;
            d5_reg.q_y     <= '0;
        end
    end

    assign dv_valid[0] = v5_reg;
    assign dv_data[0]  = d5_reg;

    for (genvar j = 0; j < DS; j++) begin : g_div
        segi_div_step #(
            .BIT_IDX(DS - 1 - j)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (dv_valid[j]),
            .in_data  (dv_data[j]),
            .out_valid(dv_valid[j+1]),
            .out_data (dv_data[j+1])
        );
    end

    always_comb begin
        sum_x = dv_data[DS].neg_x
              ? SUM_W'(dv_data[DS].start_x) - $signed({1'b0, dv_data[DS].q_x})
              : SUM_W'(dv_data[DS].start_x) + $signed({1'b0, dv_data[DS].q_x});
        sum_y = dv_data[DS].neg_y
              ? SUM_W'(dv_data[DS].start_y) - $signed({1'b0, dv_data[DS].q_y})
              : SUM_W'(dv_data[DS].start_y) + $signed({1'b0, dv_data[DS].q_y});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.hit     <= dv_data[DS].hit;
            out_reg.point_x <= dv_data[DS].hit ? sat(sum_x) : '0;
            out_reg.point_y <= dv_data[DS].hit ? sat(sum_y) : '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.point_x == '0 && m_data.point_y == '0)
        else $error("miss beat with nonzero point");

    a_hit_den: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && hit4_reg |-> den4_reg != '0)
        else $error("hit with zero denominator");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed under stall");

    a_reset_empty: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule

>>> rtl/core/segi_div_step.sv
// ----------------------------------------------------------------------------
// segi_div_step
// One registered restoring-division step, one quotient bit for both axes.
// ----------------------------------------------------------------------------
module segi_div_step #(
    parameter int BIT_IDX = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  segi_pkg::div_t in_data,
    output logic          out_valid,
    output segi_pkg::div_t out_data
);
    import segi_pkg::*;

    logic [PROD_W-1:0] den_sh;
    logic              ge_x;
    logic              ge_y;
    logic              valid_reg;
    div_t              data_reg;
    div_t              data_next;

    assign den_sh = PROD_W'(in_data.den) << BIT_IDX;
    assign ge_x   = in_data.rem_x >= den_sh;
    assign ge_y   = in_data.rem_y >= den_sh;

    always_comb begin
        data_next = in_data;
        if (ge_x) begin
            data_next.rem_x        = in_data.rem_x - den_sh;
            data_next.q_x[BIT_IDX] = 1'b1;
        end
        if (ge_y) begin
            data_next.rem_y        = in_data.rem_y - den_sh;
            data_next.q_y[BIT_IDX] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks segment_intersection against an exact integer crossing predictor:
// directed corner pairs, then random and constructed crossing pairs, under
// phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import segi_pkg::*;

    localparam int LATENCY   = COORD_BITS + 7;
    localparam int WDOG_MAX  = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    out_t crossing_q[$];
    int   errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   wdog = 0;

    segment_intersection DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic signed [15:0] sat16(logic signed [63:0] v);
        if (v > 64'sd32767) return 16'sh7fff;
        if (v < -64'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // exact cross products fit easily in 64 bits for 16-bit inputs
    function automatic out_t predict_crossing(in_t p);
        logic signed [63:0] rx, ry, sx, sy, dx, dy, rxs, tn, un, qx, qy;
        out_t o;
        rx = 64'(p.a_end_x) - 64'(p.a_start_x);
        ry = 64'(p.a_end_y) - 64'(p.a_start_y);
        sx = 64'(p.b_end_x) - 64'(p.b_start_x);
        sy = 64'(p.b_end_y) - 64'(p.b_start_y);
        dx = 64'(p.b_start_x) - 64'(p.a_start_x);
        dy = 64'(p.b_start_y) - 64'(p.a_start_y);
        rxs = rx * sy - ry * sx;
        tn  = dx * sy - dy * sx;
        un  = dx * ry - dy * rx;
        o = '0;
        if (rxs == 0) return o;
        if (rxs < 0) begin
            rxs = -rxs; tn = -tn; un = -un;
        end
        if (tn < 0 || un < 0 || tn > rxs || un > rxs) return o;
        // tn*|r| < 2^52, no overflow; magnitude quotient then sign
        qx = (tn * (rx < 0 ? -rx : rx)) / rxs;
        qy = (tn * (ry < 0 ? -ry : ry)) / rxs;
        o.hit = 1'b1;
        o.point_x = sat16(rx < 0 ? 64'(p.a_start_x) - qx : 64'(p.a_start_x) + qx);
        o.point_y = sat16(ry < 0 ? 64'(p.a_start_y) - qy : 64'(p.a_start_y) + qy);
        return o;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (crossing_q.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    out_t e;
                    e = crossing_q.pop_front();
                    if (m_data.hit !== e.hit) begin
                        $error("hit: expected %0d actual %0d", e.hit, m_data.hit);
                        errors++;
                    end
                    if (m_data.point_x !== e.point_x) begin
                        $error("point_x: expected %0d actual %0d",
                               e.point_x, m_data.point_x);
                        errors++;
                    end
                    if (m_data.point_y !== e.point_y) begin
                        $error("point_y: expected %0d actual %0d",
                               e.point_y, m_data.point_y);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            wdog <= 0;
        end else begin
            wdog <= wdog + 1;
        end
        if (wdog >= WDOG_MAX) begin
            $display("segment_intersection: mismatch");
            $finish;
        end
    end

    // valid stays up between beats unless the sender idles
    task automatic send_pair(in_t p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        crossing_q.push_back(predict_crossing(p));
    endtask

    function automatic in_t mk(int ax, int ay, int aex, int aey,
                               int bx, int by, int bex, int bey);
        in_t p;
        p.a_start_x = 16'(ax); p.a_start_y = 16'(ay);
        p.a_end_x = 16'(aex);  p.a_end_y = 16'(aey);
        p.b_start_x = 16'(bx); p.b_start_y = 16'(by);
        p.b_end_x = 16'(bex);  p.b_end_y = 16'(bey);
        return p;
    endfunction

    task automatic test_directed();
        send_pair(mk(0, 0, 160, 160, 0, 160, 160, 0));            // plain X crossing
        send_pair(mk(0, 0, 160, 0, 0, 16, 160, 16));              // parallel
        send_pair(mk(0, 0, 160, 0, 32, 0, 320, 0));               // collinear overlap
        send_pair(mk(5, 5, 5, 5, 0, 0, 16, 16));                  // degenerate A
        send_pair(mk(0, 0, 16, 16, 7, 7, 7, 7));                  // degenerate B
        send_pair(mk(0, 0, 160, 0, 160, -16, 160, 16));           // touch at A end
        send_pair(mk(0, 0, 160, 0, 0, -16, 0, 16));               // touch at A start
        send_pair(mk(0, 0, 160, 0, 80, 0, 80, 16));               // touch at B start
        send_pair(mk(0, 0, 160, 0, 80, 16, 80, 0));               // touch at B end
        send_pair(mk(0, 0, 160, 0, 161, -16, 161, 16));           // just past
        send_pair(mk(0, 0, 160, 0, 80, 1, 80, 16));               // just above
        send_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_pair(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_pair(mk(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768));
        send_pair(mk(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send_pair(mk(0, 0, 3, 7, 0, 5, 3, -2));                   // truncation
        send_pair(mk(0, 0, -3, -7, 0, -5, -3, 2));                // negative truncation
        send_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1));
    endtask

    function automatic int rc();
        case ($urandom_range(3))
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(511) - 256;
            2: return $urandom_range(1) ? 32767 - $urandom_range(7)
                                        : -32768 + $urandom_range(7);
            default: return $urandom_range(63) - 32;
        endcase
    endfunction

    // random pairs; most are built around a shared point so they tend to cross
    task automatic test_random(int n);
        in_t p;
        int cx, cy;
        repeat (n) begin
            if ($urandom_range(99) < 60) begin
                cx = rc(); cy = rc();
                p = mk(cx - rc() / 2, cy - rc() / 2, cx + rc() / 2, cy + rc() / 2,
                       cx - rc() / 2, cy - rc() / 2, cx + rc() / 2, cy + rc() / 2);
            end else if ($urandom_range(9) == 0) begin
                cx = rc();
                p = mk(cx, rc(), cx, rc(), cx, rc(), cx, rc());    // all vertical
            end else begin
                p = {$urandom(), $urandom(), $urandom(), $urandom()};
            end
            send_pair(p);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (crossing_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(150);
        drain();                                   // sender holds off until empty
        send_idle_pct = 51;
        test_random(150);
        send_idle_pct = 0; recv_stall_pct = 51;
        test_random(150);
        send_idle_pct = 15; recv_stall_pct = 15;
        test_random(150);
        recv_stall_pct = 0;
        drain();
        if (errors == 0) begin
            $display("segment_intersection: match");
        end else begin
            $display("segment_intersection: mismatch");
        end
        $finish;
    end
endmodule
